// File: src/rmdr_pkg.sv
package rmdr_pkg;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHECK,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_OUT
  } rmdr_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;       // take the operands of a new item
    logic mul;           // form the two product magnitudes and signs
    logic gcd_load;      // load the gcd unit with the product magnitudes
    logic gcd_step;      // one binary gcd step
    logic div_load_num;  // latch the gcd and start dividing the numerator
    logic div_load_den;  // keep the numerator quotient and start on the denominator
    logic div_step;      // one restoring division step
    logic out_load;      // load the result register
  } rmdr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic zero;          // one product is zero, so no reduction
    logic gcd_done;      // gcd unit has converged
    logic div_done;      // divider has produced all quotient bits
  } rmdr_status_t;

endpackage

// File: src/rational_mul_div_reduce_core.sv
// Multiplies or divides two signed fractions and reduces the result by the
// gcd of its magnitudes; signs are kept as the products give them and a result
// with a zero part leaves unreduced. One item is worked on at a time: the item
// is captured, the two products are formed and the zero check is made, then a
// binary gcd unit finds the gcd in at most 4*OPERAND_WIDTH steps, then a
// shared one-bit-per-cycle divider divides the numerator and then the
// denominator by it, and the result register is loaded; when a product is
// zero, the gcd unit and the divider are skipped.
// The result register holds a finished item while the next one is accepted.
module rational_mul_div_reduce_core #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_func,
  input  logic signed [OPERAND_WIDTH-1:0] in_a_num,
  input  logic signed [OPERAND_WIDTH-1:0] in_a_den,
  input  logic signed [OPERAND_WIDTH-1:0] in_b_num,
  input  logic signed [OPERAND_WIDTH-1:0] in_b_den,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [31:0]              out_res_num,
  output logic signed [31:0]              out_res_den
);

  rmdr_pkg::rmdr_cmd_t    cmd;
  rmdr_pkg::rmdr_status_t sts;

  // Sequencer.
  rmdr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Products, gcd unit, divider and result register.
  rmdr_dp #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .sts         (sts),
    .in_func     (in_func),
    .in_a_num    (in_a_num),
    .in_a_den    (in_a_den),
    .in_b_num    (in_b_num),
    .in_b_den    (in_b_den),
    .out_res_num (out_res_num),
    .out_res_den (out_res_den)
  );

endmodule

// File: src/rmdr_ctrl.sv
module rmdr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  rmdr_pkg::rmdr_status_t sts,
  output rmdr_pkg::rmdr_cmd_t    cmd
);

  rmdr_pkg::rmdr_state_t state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_free;

  // The result register can take a new item when it is empty or being drained.
  assign out_free = !out_valid_r || !out_stall;

  // State and result-valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rmdr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rmdr_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = rmdr_pkg::ST_MUL;
      end
      rmdr_pkg::ST_MUL: begin
        state_nxt = rmdr_pkg::ST_CHECK;
      end
      rmdr_pkg::ST_CHECK: begin
        state_nxt = sts.zero ? rmdr_pkg::ST_OUT : rmdr_pkg::ST_GCD;
      end
      rmdr_pkg::ST_GCD: begin
        if (sts.gcd_done) state_nxt = rmdr_pkg::ST_DIVN;
      end
      rmdr_pkg::ST_DIVN: begin
        if (sts.div_done) state_nxt = rmdr_pkg::ST_DIVD;
      end
      rmdr_pkg::ST_DIVD: begin
        if (sts.div_done) state_nxt = rmdr_pkg::ST_OUT;
      end
      rmdr_pkg::ST_OUT: begin
        if (out_free) state_nxt = rmdr_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = rmdr_pkg::ST_IDLE;
      end
    endcase
  end

  // Command and handshake outputs.
  always_comb begin
    cmd           = '0;
    in_stall      = 1'b1;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      rmdr_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      rmdr_pkg::ST_MUL: begin
        cmd.mul = 1'b1;
      end
      rmdr_pkg::ST_CHECK: begin
        cmd.gcd_load = !sts.zero;
      end
      rmdr_pkg::ST_GCD: begin
        cmd.gcd_step     = !sts.gcd_done;
        cmd.div_load_num = sts.gcd_done;
      end
      rmdr_pkg::ST_DIVN: begin
        cmd.div_step     = !sts.div_done;
        cmd.div_load_den = sts.div_done;
      end
      rmdr_pkg::ST_DIVD: begin
        cmd.div_step = !sts.div_done;
      end
      rmdr_pkg::ST_OUT: begin
        cmd.out_load = out_free;
        if (out_free) out_valid_nxt = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// File: src/rmdr_dp.sv
module rmdr_dp #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                            clk,
  input  rmdr_pkg::rmdr_cmd_t             cmd,
  output rmdr_pkg::rmdr_status_t          sts,
  input  logic                            in_func,
  input  logic signed [OPERAND_WIDTH-1:0] in_a_num,
  input  logic signed [OPERAND_WIDTH-1:0] in_a_den,
  input  logic signed [OPERAND_WIDTH-1:0] in_b_num,
  input  logic signed [OPERAND_WIDTH-1:0] in_b_den,
  output logic signed [31:0]              out_res_num,
  output logic signed [31:0]              out_res_den
);

  localparam int W  = OPERAND_WIDTH;
  localparam int PW = 2 * OPERAND_WIDTH;
  localparam int KW = $clog2(PW + 1);
  localparam int CW = $clog2(PW + 1);

  // Operand registers: numerator pair and denominator pair after operation select.
  logic signed [W-1:0] n1_r, n2_r, d1_r, d2_r;
  logic        [W-1:0] n1_mag, n2_mag, d1_mag, d2_mag;

  // Product magnitudes and signs.
  logic [PW-1:0] pn_mag_r, pd_mag_r;
  logic          sn_r, sd_r;

  // Binary gcd unit.
  logic [PW-1:0] ga_r, gb_r, ga_nxt, gb_nxt;
  logic [KW-1:0] gk_r, gk_nxt;
  logic [PW:0]   g_diff;
  logic [PW-1:0] g_diff_neg;

  // Shared restoring divider.
  logic [PW-1:0] g_r;
  logic [PW-1:0] rem_r, rem_nxt;
  logic [PW-1:0] dq_r, dq_nxt;
  logic [CW-1:0] cnt_r;
  logic [PW:0]   rem_sh, trial;
  logic          fits;
  logic [PW-1:0] qn_r;

  // Result formation.
  logic [PW-1:0]        num_mag, den_mag;
  logic signed [PW:0]   num_val, den_val;
  logic signed [31:0]   res_num_r, res_den_r;

  // Operand capture; a divide swaps the second fraction.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      n1_r <= in_a_num;
      d1_r <= in_a_den;
      n2_r <= in_func ? in_b_den : in_b_num;
      d2_r <= in_func ? in_b_num : in_b_den;
    end
  end

  // Operand magnitudes; the most negative value maps onto its unsigned magnitude.
  assign n1_mag = n1_r[W-1] ? $unsigned(-n1_r) : $unsigned(n1_r);
  assign n2_mag = n2_r[W-1] ? $unsigned(-n2_r) : $unsigned(n2_r);
  assign d1_mag = d1_r[W-1] ? $unsigned(-d1_r) : $unsigned(d1_r);
  assign d2_mag = d2_r[W-1] ? $unsigned(-d2_r) : $unsigned(d2_r);

  // Product stage.
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      pn_mag_r <= PW'(n1_mag) * PW'(n2_mag);
      pd_mag_r <= PW'(d1_mag) * PW'(d2_mag);
      sn_r     <= n1_r[W-1] ^ n2_r[W-1];
      sd_r     <= d1_r[W-1] ^ d2_r[W-1];
    end
  end

  assign sts.zero = (pn_mag_r == '0) || (pd_mag_r == '0);

  // One binary gcd step: strip common twos, strip lone twos, or subtract odd values.
  assign g_diff     = {1'b0, ga_r} - {1'b0, gb_r};
  assign g_diff_neg = gb_r - ga_r;

  always_comb begin
    ga_nxt = ga_r;
    gb_nxt = gb_r;
    gk_nxt = gk_r;
    if (!ga_r[0] && !gb_r[0]) begin
      ga_nxt = ga_r >> 1;
      gb_nxt = gb_r >> 1;
      gk_nxt = gk_r + KW'(1);
    end else if (!ga_r[0]) begin
      ga_nxt = ga_r >> 1;
    end else if (!gb_r[0]) begin
      gb_nxt = gb_r >> 1;
    end else if (!g_diff[PW]) begin
      ga_nxt = g_diff[PW-1:0] >> 1;
    end else begin
      gb_nxt = g_diff_neg >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.gcd_load) begin
      ga_r <= pn_mag_r;
      gb_r <= pd_mag_r;
      gk_r <= '0;
    end else if (cmd.gcd_step) begin
      ga_r <= ga_nxt;
      gb_r <= gb_nxt;
      gk_r <= gk_nxt;
    end
  end

  assign sts.gcd_done = (ga_r == gb_r);

  // Divider step: shift in the next dividend bit and subtract the gcd when it fits.
  assign rem_sh  = {rem_r, dq_r[PW-1]};
  assign trial   = rem_sh - {1'b0, g_r};
  assign fits    = !trial[PW];
  assign rem_nxt = fits ? trial[PW-1:0] : rem_sh[PW-1:0];
  assign dq_nxt  = {dq_r[PW-2:0], fits};

  always_ff @(posedge clk) begin
    if (cmd.div_load_num) begin
      g_r   <= ga_r << gk_r;
      rem_r <= '0;
      dq_r  <= pn_mag_r;
      cnt_r <= '0;
    end else if (cmd.div_load_den) begin
      qn_r  <= dq_r;
      rem_r <= '0;
      dq_r  <= pd_mag_r;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      dq_r  <= dq_nxt;
      cnt_r <= cnt_r + CW'(1);
    end
  end

  assign sts.div_done = (cnt_r == CW'(PW));

  // Reapply signs and fit the results to 32 bits.
  assign num_mag = sts.zero ? pn_mag_r : qn_r;
  assign den_mag = sts.zero ? pd_mag_r : dq_r;
  assign num_val = sn_r ? -$signed({1'b0, num_mag}) : $signed({1'b0, num_mag});
  assign den_val = sd_r ? -$signed({1'b0, den_mag}) : $signed({1'b0, den_mag});

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_num_r <= 32'(num_val);
      res_den_r <= 32'(den_val);
    end
  end

  assign out_res_num = res_num_r;
  assign out_res_den = res_den_r;

endmodule

// File: src/rmdr_checker.sv
module rmdr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_res_num,
  input logic [31:0] out_res_den
);

  // A stalled result stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_res_num) && $stable(out_res_den))
    else $error("stalled result changed");

  // Once an item is taken the block is busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted while still busy");

  // A new result only appears while the input side is busy finishing an item.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item in progress");

endmodule

bind rational_mul_div_reduce_core rmdr_checker u_rmdr_checker (.*);

// File: sim/tb_rational_mul_div_reduce_core.sv
module tb_rational_mul_div_reduce_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OPW          = 16;
  localparam int RANDOM_ITEMS = 600;
  localparam int QUIET_TAIL   = 60;
  localparam int DRAIN_CYCLES = 200;

  // Operation codes on in_func.
  localparam logic OP_MUL = 1'b0;
  localparam logic OP_DIV = 1'b1;

  typedef logic signed [OPW-1:0] operand_t;

  typedef struct packed {
    logic signed [31:0] num;
    logic signed [31:0] den;
  } ratio_t;

  typedef struct {
    logic     op;
    operand_t a_num;
    operand_t a_den;
    operand_t b_num;
    operand_t b_den;
    bit       typed;
    ratio_t   want;
  } stim_row_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic               in_func   = OP_MUL;
  operand_t           in_a_num  = '0;
  operand_t           in_a_den  = '0;
  operand_t           in_b_num  = '0;
  operand_t           in_b_den  = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_res_num;
  logic signed [31:0] out_res_den;

  ratio_t    pending_ratios[$];
  stim_row_t directed_rows[$];
  int        mismatches = 0;
  bit        quiet      = 1'b0;

  rational_mul_div_reduce_core #(
    .OPERAND_WIDTH(OPW)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_func    (in_func),
    .in_a_num   (in_a_num),
    .in_a_den   (in_a_den),
    .in_b_num   (in_b_num),
    .in_b_den   (in_b_den),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res_num(out_res_num),
    .out_res_den(out_res_den)
  );

  // Free-running clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Hard limit on the length of the run.
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // Forms both products exactly, then divides each by the gcd of their
  // magnitudes; a zero part leaves the pair as it stands.
  function automatic ratio_t reduced_ratio(logic op, operand_t an, operand_t ad,
                                           operand_t bn, operand_t bd);
    longint          pn;
    longint          pd;
    longint unsigned mn;
    longint unsigned md;
    longint unsigned x;
    longint unsigned y;
    longint unsigned t;
    ratio_t          r;
    if (op == OP_DIV) begin
      pn = longint'(an) * longint'(bd);
      pd = longint'(ad) * longint'(bn);
    end else begin
      pn = longint'(an) * longint'(bn);
      pd = longint'(ad) * longint'(bd);
    end
    if (pn != 0 && pd != 0) begin
      mn = (pn < 0) ? -pn : pn;
      md = (pd < 0) ? -pd : pd;
      x  = mn;
      y  = md;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      mn = mn / x;
      md = md / x;
      pn = (pn < 0) ? -longint'(mn) : longint'(mn);
      pd = (pd < 0) ? -longint'(md) : longint'(md);
    end
    r.num = pn[31:0];
    r.den = pd[31:0];
    return r;
  endfunction

  function automatic operand_t small_operand();
    return operand_t'(int'($urandom_range(0, 40)) - 20);
  endfunction

  function automatic operand_t extreme_operand();
    case ($urandom_range(0, 4))
      0:       return operand_t'(-32768);
      1:       return operand_t'(-1);
      2:       return operand_t'(0);
      3:       return operand_t'(1);
      default: return operand_t'(32767);
    endcase
  endfunction

  // A multiple of k that still fits the operand width.
  function automatic operand_t scaled_operand(int k);
    int lim;
    lim = 32767 / k;
    return operand_t'(k * (int'($urandom_range(0, 2 * lim)) - lim));
  endfunction

  // Full-range operands as the largest share, with small values, common factors,
  // zero parts and extremes so that the reduction is exercised in depth.
  function automatic stim_row_t make_random_row();
    stim_row_t r;
    int        kind;
    int        k;
    kind    = $urandom_range(0, 9);
    r.op    = logic'($urandom_range(0, 1));
    r.typed = 1'b0;
    r.want  = '0;
    r.a_num = operand_t'($urandom);
    r.a_den = operand_t'($urandom);
    r.b_num = operand_t'($urandom);
    r.b_den = operand_t'($urandom);
    case (kind)
      4, 5: begin
        r.a_num = small_operand();
        r.a_den = small_operand();
        r.b_num = small_operand();
        r.b_den = small_operand();
      end
      6: begin
        case ($urandom_range(0, 3))
          0:       r.a_num = '0;
          1:       r.a_den = '0;
          2:       r.b_num = '0;
          default: r.b_den = '0;
        endcase
      end
      7, 8: begin
        k       = $urandom_range(2, 181);
        r.a_num = scaled_operand(k);
        r.a_den = scaled_operand(k);
        r.b_num = scaled_operand(k);
        r.b_den = scaled_operand(k);
      end
      9: begin
        r.a_num = extreme_operand();
        r.a_den = extreme_operand();
        r.b_num = extreme_operand();
        r.b_den = extreme_operand();
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int pick_gap(int rate);
    if (rate != 0 && $urandom_range(0, 9) < rate) return $urandom_range(1, 11);
    return 0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_result(input ratio_t got);
    ratio_t want;
    if (pending_ratios.size() == 0) begin
      report_mismatch($sformatf("result %0d/%0d with no item outstanding",
                                got.num, got.den));
      return;
    end
    want = pending_ratios.pop_front();
    if (got.num !== want.num)
      report_mismatch($sformatf("res_num %0d, expected %0d", got.num, want.num));
    if (got.den !== want.den)
      report_mismatch($sformatf("res_den %0d, expected %0d", got.den, want.den));
  endtask

  // Presents one item after an optional gap and holds it until accepted.
  task automatic drive_item(input stim_row_t row, input int gap);
    ratio_t want;
    want = row.typed ? row.want
                     : reduced_ratio(row.op, row.a_num, row.a_den, row.b_num, row.b_den);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= row.op;
    in_a_num <= row.a_num;
    in_a_den <= row.a_den;
    in_b_num <= row.b_num;
    in_b_den <= row.b_den;
    do @(posedge clk); while (in_stall);
    pending_ratios.push_back(want);
  endtask

  // Withdraws the sender until every outstanding item has produced its result.
  task automatic idle_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_ratios.size() != 0) @(posedge clk);
  endtask

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result('{out_res_num, out_res_den});
  end

  // Receiver stalls in bursts; the burst rate is redrawn every 128 passes of its loop.
  initial begin
    int rate;
    int cycle;
    rate  = 0;
    cycle = 0;
    forever begin
      @(negedge clk);
      if (cycle % 128 == 0) rate = $urandom_range(0, 3);
      cycle++;
      if (!quiet && rate != 0 && $urandom_range(0, 9) < rate) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int gap_rate;
    // Directed items: zero parts, sign handling, operand extremes and common factors.
    directed_rows.push_back('{OP_MUL, 0, 4, 3, 6, 1'b1, '{0, 24}});
    directed_rows.push_back('{OP_DIV, 1, 2, 0, 5, 1'b1, '{5, 0}});
    directed_rows.push_back('{OP_DIV, 5, 0, 3, 2, 1'b1, '{10, 0}});
    directed_rows.push_back('{OP_MUL, 0, 0, 0, 0, 1'b1, '{0, 0}});
    directed_rows.push_back('{OP_DIV, 0, 0, 0, 0, 1'b1, '{0, 0}});
    directed_rows.push_back('{OP_MUL, 0, -5, 7, 3, 1'b1, '{0, -15}});
    directed_rows.push_back('{OP_MUL, -32768, 1, -32768, 1, 1'b1, '{1073741824, 1}});
    directed_rows.push_back('{OP_MUL, 32767, 32767, 32767, 32767, 1'b1, '{1, 1}});
    directed_rows.push_back('{OP_MUL, -32768, -32768, 32767, 32767, 1'b1, '{-1, -1}});
    directed_rows.push_back('{OP_MUL, 32767, -32768, 32767, -32768, 1'b1,
                              '{1073676289, 1073741824}});
    directed_rows.push_back('{OP_DIV, -32768, 32767, 32767, -32768, 1'b1,
                              '{1073741824, 1073676289}});
    directed_rows.push_back('{OP_MUL, 1, -1, 1, 1, 1'b1, '{1, -1}});
    directed_rows.push_back('{OP_MUL, -2, -4, 1, 1, 1'b1, '{-1, -2}});
    directed_rows.push_back('{OP_DIV, 3, 4, 3, 4, 1'b1, '{1, 1}});
    directed_rows.push_back('{OP_DIV, -1, 1, -1, 1, 1'b1, '{-1, -1}});
    directed_rows.push_back('{OP_MUL, 1, 1, 1, 1, 1'b1, '{1, 1}});
    directed_rows.push_back('{OP_DIV, 6, 35, 10, 21, 1'b0, '{0, 0}});
    directed_rows.push_back('{OP_MUL, -12, 25, 10, -9, 1'b0, '{0, 0}});
    directed_rows.push_back('{OP_DIV, 12345, -777, -4321, 999, 1'b0, '{0, 0}});
    directed_rows.push_back('{OP_MUL, -32767, 255, 4096, -32768, 1'b0, '{0, 0}});

    // Hold reset, then release it on a falling edge.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    gap_rate = $urandom_range(0, 3);
    foreach (directed_rows[i]) drive_item(directed_rows[i], pick_gap(gap_rate));
    idle_until_drained();

    // Random items; the sender's gap rate changes every 32 items.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 32 == 0) gap_rate = $urandom_range(0, 3);
      if (i == RANDOM_ITEMS / 2) idle_until_drained();
      if (i == RANDOM_ITEMS - QUIET_TAIL) quiet = 1'b1;
      drive_item(make_random_row(), quiet ? 0 : pick_gap(gap_rate));
    end

    // Let the last results arrive, then allow for any stray output.
    idle_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
